// File: design/route_block_sequencer_unit_defines.svh
// Assertion macros shared by the route block sequencer RTL.
`ifndef ROUTE_BLOCK_SEQUENCER_UNIT_DEFINES_SVH
`define ROUTE_BLOCK_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define RBS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define RBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/rbs_pkg.sv
// Types, codes and constants of the route block sequencer.
package rbs_pkg;

	localparam logic [31:0] EXIT_THRESHOLD = 32'h0000_8000;
	localparam logic [31:0] DEFAULT_DELAY  = 32'd6000;

	localparam logic REQ_START = 1'b1;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ROUTE_MASK     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEVER_PRESENT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_PRESENT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RELAY_PRESENT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVATE_DELAY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_DELAY     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_UNBLOCK_DELAY  = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE        = 3'd0,
		ST_TRIGGERED   = 3'd1,
		ST_WAITKEY     = 3'd2,
		ST_UNBLOCK     = 3'd3,
		ST_WAITRELEASE = 3'd4
	} seq_state_t;

	typedef struct packed {
		logic [31:0] route_mask;
		logic        lever_present;
		logic        key_present;
		logic        relay_present;
		logic [31:0] activate_delay;
		logic [31:0] keep_delay;
		logic [31:0] unblock_delay;
		logic [31:0] act_keep_sum;
	} cfg_t;

	typedef struct packed {
		logic        req_type;
		logic [31:0] now;
		logic [31:0] switch_states;
		logic        lever_on;
		logic        key_level;
		logic        section_free;
		logic        has_permission;
		logic        wait_for_key;
	} item_t;

	// deadlines for a fresh start, and whether each one already lies behind now
	typedef struct packed {
		logic [31:0] act_sum;
		logic [31:0] deact_sum;
		logic [31:0] unb_sum;
		logic        act_wrap;
		logic        deact_wrap;
		logic        unb_wrap;
	} prep_t;

	typedef struct packed {
		seq_state_t  seq;
		logic [31:0] act_dl;
		logic        act_armed;
		logic [31:0] deact_dl;
		logic        deact_armed;
		logic [31:0] unb_dl;
		logic        unb_armed;
		logic        relay;
	} ctx_t;

	typedef struct packed {
		logic [2:0] ctrl_state;
		logic       relay_level;
		logic       block_cmd;
		logic       set_start_cmd;
		logic       reset_end_cmd;
		logic       route_active;
	} result_t;

endpackage

// File: design/rbs_if.sv
// Item, result and configuration channel interfaces.
interface rbs_item_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [31:0] now;
	logic [31:0] switch_states;
	logic        lever_on;
	logic        key_level;
	logic        section_free;
	logic        has_permission;
	logic        wait_for_key;

	modport source (
		output valid, req_type, now, switch_states, lever_on, key_level,
			section_free, has_permission, wait_for_key,
		input  ready
	);
	modport sink (
		input  valid, req_type, now, switch_states, lever_on, key_level,
			section_free, has_permission, wait_for_key,
		output ready
	);
endinterface

interface rbs_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] ctrl_state;
	logic       relay_level;
	logic       block_cmd;
	logic       set_start_cmd;
	logic       reset_end_cmd;
	logic       route_active;

	modport source (
		output valid, ctrl_state, relay_level, block_cmd, set_start_cmd,
			reset_end_cmd, route_active,
		input  ready
	);
	modport sink (
		input  valid, ctrl_state, relay_level, block_cmd, set_start_cmd,
			reset_end_cmd, route_active,
		output ready
	);
endinterface

interface rbs_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: design/rbs_core.sv
// Next-state and result logic for one item of the route block sequencer.
module rbs_core (
	input  rbs_pkg::cfg_t    cfg,
	input  rbs_pkg::item_t   item,
	input  rbs_pkg::prep_t   prep,
	input  rbs_pkg::ctx_t    ctx,
	output rbs_pkg::ctx_t    ctx_next,
	output rbs_pkg::result_t res
);
	import rbs_pkg::*;

	logic is_exit;
	logic route_hit;
	logic act_late;
	logic deact_late;
	logic unb_late;
	logic trig;
	logic unb_new;
	logic act_fire;
	logic deact_fire;
	logic unb_fire;

	assign is_exit    = cfg.route_mask > EXIT_THRESHOLD;
	assign route_hit  = |(~item.switch_states & cfg.route_mask);
	assign act_late   = item.now > ctx.act_dl;
	assign deact_late = item.now > ctx.deact_dl;
	assign unb_late   = item.now > ctx.unb_dl;

	always_comb begin
		ctx_next   = ctx;
		res        = '0;
		trig       = 1'b0;
		unb_new    = 1'b0;
		act_fire   = 1'b0;
		deact_fire = 1'b0;
		unb_fire   = 1'b0;

		if (item.req_type == REQ_START) begin
			if (cfg.key_present && item.wait_for_key) begin
				ctx_next.seq = ST_WAITKEY;
			end else begin
				ctx_next.seq       = ST_UNBLOCK;
				ctx_next.unb_dl    = prep.unb_sum;
				ctx_next.unb_armed = 1'b1;
			end
		end else if (route_hit) begin
			res.route_active = 1'b1;
			unique case (ctx.seq)
				ST_IDLE: begin
					if (cfg.lever_present && item.lever_on && item.section_free &&
						(is_exit == item.has_permission)) begin
						trig                 = 1'b1;
						ctx_next.seq         = ST_TRIGGERED;
						ctx_next.act_dl      = prep.act_sum;
						ctx_next.deact_dl    = prep.deact_sum;
						ctx_next.act_armed   = 1'b1;
						ctx_next.deact_armed = 1'b1;
					end
				end
				ST_WAITKEY: begin
					if (!item.key_level) begin
						unb_new            = 1'b1;
						ctx_next.seq       = ST_UNBLOCK;
						ctx_next.unb_dl    = prep.unb_sum;
						ctx_next.unb_armed = 1'b1;
					end
				end
				ST_WAITRELEASE: begin
					if (!cfg.lever_present || !item.lever_on) begin
						if (cfg.lever_present) begin
							res.set_start_cmd = is_exit;
							res.reset_end_cmd = !is_exit;
						end
						ctx_next.seq = ST_IDLE;
					end
				end
				default: begin
				end
			endcase

			act_fire = ctx_next.act_armed && (trig ? prep.act_wrap : act_late);
			if (act_fire) begin
				if (cfg.relay_present) begin
					ctx_next.relay = 1'b0;
				end
				ctx_next.act_armed = 1'b0;
			end

			deact_fire = ctx_next.deact_armed && (trig ? prep.deact_wrap : deact_late);
			if (deact_fire) begin
				if (cfg.relay_present) begin
					ctx_next.relay = 1'b1;
				end
				ctx_next.deact_armed = 1'b0;
				if (cfg.key_present) begin
					ctx_next.seq = ST_WAITKEY;
				end else begin
					unb_new            = 1'b1;
					ctx_next.seq       = ST_UNBLOCK;
					ctx_next.unb_dl    = prep.unb_sum;
					ctx_next.unb_armed = 1'b1;
				end
			end

			unb_fire = ctx_next.unb_armed && (unb_new ? prep.unb_wrap : unb_late);
			if (unb_fire) begin
				res.block_cmd      = 1'b1;
				ctx_next.seq       = ST_WAITRELEASE;
				ctx_next.unb_armed = 1'b0;
			end
		end

		res.ctrl_state  = ctx_next.seq;
		res.relay_level = ctx_next.relay;
	end

endmodule

// File: design/route_block_sequencer_unit.sv
// Top level of the route block sequencer: config registers, pipeline and state.
// Path: an accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle; a waiting result stalls the input once the input register is full.
// Deadline sums and their wrap checks are formed as the item enters the input register.
// Reset: asynchronous, active low; config returns to defaults, sequencer goes idle,
// all deadlines disarmed, relay released. No clearing pass.
`include "route_block_sequencer_unit_defines.svh"

module route_block_sequencer_unit (
	input logic         clk,
	input logic         arst_n,
	rbs_item_if.sink    item,
	rbs_result_if.source result,
	rbs_cfg_if.sink     cfg
);
	import rbs_pkg::*;

	cfg_t    cfg_q;
	ctx_t    ctx_q;
	ctx_t    ctx_next;
	item_t   item_d;
	item_t   item_s1;
	prep_t   prep_d;
	prep_t   prep_s1;
	logic    s1_valid_q;
	result_t res_d;
	result_t res_s2;
	logic    out_valid_s2;
	logic    advance;
	logic    item_take;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.route_mask     <= '0;
			cfg_q.lever_present  <= 1'b1;
			cfg_q.key_present    <= 1'b0;
			cfg_q.relay_present  <= 1'b1;
			cfg_q.activate_delay <= DEFAULT_DELAY;
			cfg_q.keep_delay     <= DEFAULT_DELAY;
			cfg_q.unblock_delay  <= DEFAULT_DELAY;
			cfg_q.act_keep_sum   <= DEFAULT_DELAY + DEFAULT_DELAY;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_ROUTE_MASK:    cfg_q.route_mask    <= cfg.data;
				REG_LEVER_PRESENT: cfg_q.lever_present <= cfg.data[0];
				REG_KEY_PRESENT:   cfg_q.key_present   <= cfg.data[0];
				REG_RELAY_PRESENT: cfg_q.relay_present <= cfg.data[0];
				REG_ACTIVATE_DELAY: begin
					cfg_q.activate_delay <= cfg.data;
					cfg_q.act_keep_sum   <= cfg.data + cfg_q.keep_delay;
				end
				REG_KEEP_DELAY: begin
					cfg_q.keep_delay   <= cfg.data;
					cfg_q.act_keep_sum <= cfg_q.activate_delay + cfg.data;
				end
				REG_UNBLOCK_DELAY: cfg_q.unblock_delay <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// input stage
	assign item_d.req_type       = item.req_type;
	assign item_d.now            = item.now;
	assign item_d.switch_states  = item.switch_states;
	assign item_d.lever_on       = item.lever_on;
	assign item_d.key_level      = item.key_level;
	assign item_d.section_free   = item.section_free;
	assign item_d.has_permission = item.has_permission;
	assign item_d.wait_for_key   = item.wait_for_key;

	assign prep_d.act_sum    = item.now + cfg_q.activate_delay;
	assign prep_d.deact_sum  = item.now + cfg_q.act_keep_sum;
	assign prep_d.unb_sum    = item.now + cfg_q.unblock_delay;
	assign prep_d.act_wrap   = item.now > prep_d.act_sum;
	assign prep_d.deact_wrap = item.now > prep_d.deact_sum;
	assign prep_d.unb_wrap   = item.now > prep_d.unb_sum;

	assign advance    = s1_valid_q && (!out_valid_s2 || result.ready);
	assign item.ready = !s1_valid_q || advance;
	assign item_take  = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= item_take || (s1_valid_q && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			item_s1 <= item_d;
			prep_s1 <= prep_d;
		end
	end

	rbs_core u_core (
		.cfg      (cfg_q),
		.item     (item_s1),
		.prep     (prep_s1),
		.ctx      (ctx_q),
		.ctx_next (ctx_next),
		.res      (res_d)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.seq         <= ST_IDLE;
			ctx_q.act_dl      <= '0;
			ctx_q.act_armed   <= 1'b0;
			ctx_q.deact_dl    <= '0;
			ctx_q.deact_armed <= 1'b0;
			ctx_q.unb_dl      <= '0;
			ctx_q.unb_armed   <= 1'b0;
			ctx_q.relay       <= 1'b1;
		end else if (advance) begin
			ctx_q <= ctx_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (result.ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign result.valid         = out_valid_s2;
	assign result.ctrl_state    = res_s2.ctrl_state;
	assign result.relay_level   = res_s2.relay_level;
	assign result.block_cmd     = res_s2.block_cmd;
	assign result.set_start_cmd = res_s2.set_start_cmd;
	assign result.reset_end_cmd = res_s2.reset_end_cmd;
	assign result.route_active  = res_s2.route_active;

	`RBS_ASSERT_NOW(a_blk_state, result.valid && result.block_cmd, result.ctrl_state == ST_WAITRELEASE, "block command without wait release")
	`RBS_ASSERT_NOW(a_pulse_route, result.valid && !result.route_active, !result.block_cmd && !result.set_start_cmd && !result.reset_end_cmd, "pulse on inactive route")
	`RBS_ASSERT_NOW(a_unb_armed, ctx_q.seq == ST_UNBLOCK, ctx_q.unb_armed, "unblock pending with no deadline")
	`RBS_ASSERT_NOW(a_trig_armed, ctx_q.seq == ST_TRIGGERED, ctx_q.deact_armed, "triggered with no release deadline")
	`RBS_ASSERT_NEXT(a_s1_hold, s1_valid_q && !advance, s1_valid_q, "stalled item lost")

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the route block sequencer: scoreboard, drivers and stimulus.
`timescale 1ns / 100ps

module testbench;
	import rbs_pkg::*;

	localparam logic REQ_TICK = 1'b0;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 210;

	class rbs_scoreboard;
		logic [31:0] route_mask;
		logic        lever_present;
		logic        key_present;
		logic        relay_present;
		logic [31:0] activate_delay;
		logic [31:0] keep_delay;
		logic [31:0] unblock_delay;
		seq_state_t  seq;
		logic [31:0] act_dl;
		logic [31:0] deact_dl;
		logic [31:0] unb_dl;
		logic        act_armed;
		logic        deact_armed;
		logic        unb_armed;
		logic        relay;
		result_t     expected_status[$];
		int          errors;
		int          n_items;
		int          n_checked;
		int          n_block;
		int          n_release;

		function new();
			route_mask     = '0;
			lever_present  = 1'b1;
			key_present    = 1'b0;
			relay_present  = 1'b1;
			activate_delay = DEFAULT_DELAY;
			keep_delay     = DEFAULT_DELAY;
			unblock_delay  = DEFAULT_DELAY;
			seq            = ST_IDLE;
			act_dl         = '0;
			deact_dl       = '0;
			unb_dl         = '0;
			act_armed      = 1'b0;
			deact_armed    = 1'b0;
			unb_armed      = 1'b0;
			relay          = 1'b1;
			errors         = 0;
			n_items        = 0;
			n_checked      = 0;
			n_block        = 0;
			n_release      = 0;
		endfunction

		function void configure(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				REG_ROUTE_MASK:     route_mask = data;
				REG_LEVER_PRESENT:  lever_present = data[0];
				REG_KEY_PRESENT:    key_present = data[0];
				REG_RELAY_PRESENT:  relay_present = data[0];
				REG_ACTIVATE_DELAY: activate_delay = data;
				REG_KEEP_DELAY:     keep_delay = data;
				REG_UNBLOCK_DELAY:  unblock_delay = data;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_status.size();
		endfunction

		function void start_unblock(logic [31:0] now);
			seq       = ST_UNBLOCK;
			unb_dl    = now + unblock_delay;
			unb_armed = 1'b1;
		endfunction

		function result_t advance_sequencer(item_t it);
			result_t r;
			logic    is_exit;
			r       = '0;
			is_exit = route_mask > EXIT_THRESHOLD;
			if (it.req_type == REQ_START) begin
				if (key_present && it.wait_for_key)
					seq = ST_WAITKEY;
				else
					start_unblock(it.now);
			end else if ((~it.switch_states & route_mask) != '0) begin
				r.route_active = 1'b1;
				case (seq)
					ST_IDLE: begin
						if (lever_present && it.lever_on && it.section_free &&
								(is_exit == it.has_permission)) begin
							seq         = ST_TRIGGERED;
							act_dl      = it.now + activate_delay;
							deact_dl    = act_dl + keep_delay;
							act_armed   = 1'b1;
							deact_armed = 1'b1;
						end
					end
					ST_WAITKEY: begin
						if (!it.key_level)
							start_unblock(it.now);
					end
					ST_WAITRELEASE: begin
						if (!lever_present || !it.lever_on) begin
							if (lever_present) begin
								if (is_exit)
									r.set_start_cmd = 1'b1;
								else
									r.reset_end_cmd = 1'b1;
							end
							seq = ST_IDLE;
						end
					end
					default: ;
				endcase
				if (act_armed && it.now > act_dl) begin
					if (relay_present)
						relay = 1'b0;
					act_armed = 1'b0;
				end
				if (deact_armed && it.now > deact_dl) begin
					if (relay_present)
						relay = 1'b1;
					deact_armed = 1'b0;
					if (key_present)
						seq = ST_WAITKEY;
					else
						start_unblock(it.now);
				end
				if (unb_armed && it.now > unb_dl) begin
					r.block_cmd = 1'b1;
					seq         = ST_WAITRELEASE;
					unb_armed   = 1'b0;
				end
			end
			r.ctrl_state  = seq;
			r.relay_level = relay;
			return r;
		endfunction

		function void note_item(item_t it);
			expected_status.push_back(advance_sequencer(it));
			n_items++;
		endfunction

		function void compare_field(string name, logic [2:0] want, logic [2:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_status(result_t got);
			result_t want;
			if (expected_status.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
				return;
			end
			want = expected_status.pop_front();
			n_checked++;
			if (want.block_cmd)
				n_block++;
			if (want.set_start_cmd || want.reset_end_cmd)
				n_release++;
			compare_field("ctrl_state", want.ctrl_state, got.ctrl_state);
			compare_field("relay_level", want.relay_level, got.relay_level);
			compare_field("block_cmd", want.block_cmd, got.block_cmd);
			compare_field("set_start_cmd", want.set_start_cmd, got.set_start_cmd);
			compare_field("reset_end_cmd", want.reset_end_cmd, got.reset_end_cmd);
			compare_field("route_active", want.route_active, got.route_active);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rbs_item_if   item_ch();
	rbs_result_if result_ch();
	rbs_cfg_if    cfg_ch();

	route_block_sequencer_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	rbs_scoreboard scoreboard;
	int            cycle_count;
	int            rx_count;
	int            rx_mode;
	int            burst_left;
	bit            gaps_on;
	int            n_settings;
	logic [31:0]   ms_now;

	function automatic logic coin(int pct_high);
		return $urandom_range(0, 99) < pct_high;
	endfunction

	initial begin
		clk = 1'b0;
		scoreboard = new();
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("route_block_sequencer_unit test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && item_ch.valid && item_ch.ready)
			scoreboard.note_item({item_ch.req_type, item_ch.now, item_ch.switch_states,
				item_ch.lever_on, item_ch.key_level, item_ch.section_free,
				item_ch.has_permission, item_ch.wait_for_key});
		if (arst_n && result_ch.valid && result_ch.ready)
			scoreboard.check_status({result_ch.ctrl_state, result_ch.relay_level,
				result_ch.block_cmd, result_ch.set_start_cmd, result_ch.reset_end_cmd,
				result_ch.route_active});
	end

	// receiver back-pressure: a randomly drawn mode sets the ready pattern
	always @(negedge clk) begin
		rx_count++;
		if (rx_count % 300 == 0)
			rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0: result_ch.ready = 1'b1;
			1: result_ch.ready = coin(50);
			2: result_ch.ready = (rx_count % 4 == 0);
			default: result_ch.ready = coin(90);
		endcase
	end

	function automatic item_t build_item(logic req, logic [31:0] now, logic [31:0] sw,
			logic lever, logic key, logic free, logic perm, logic wkey);
		item_t it;
		it.req_type       = req;
		it.now            = now;
		it.switch_states  = sw;
		it.lever_on       = lever;
		it.key_level      = key;
		it.section_free   = free;
		it.has_permission = perm;
		it.wait_for_key   = wkey;
		return it;
	endfunction

	task automatic hold_off(int n);
		@(negedge clk);
		item_ch.valid = 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_item(item_t it);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on && coin(75))
				hold_off($urandom_range(1, 6));
		end
		burst_left--;
		@(negedge clk);
		item_ch.req_type       = it.req_type;
		item_ch.now            = it.now;
		item_ch.switch_states  = it.switch_states;
		item_ch.lever_on       = it.lever_on;
		item_ch.key_level      = it.key_level;
		item_ch.section_free   = it.section_free;
		item_ch.has_permission = it.has_permission;
		item_ch.wait_for_key   = it.wait_for_key;
		item_ch.valid          = 1'b1;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	task automatic drain();
		@(negedge clk);
		item_ch.valid = 1'b0;
		while (scoreboard.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = data;
		do @(posedge clk); while (!cfg_ch.ready);
		scoreboard.configure(idx, data);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic apply_config(logic [31:0] mask, logic lever, logic key, logic relay,
			logic [31:0] act, logic [31:0] keep, logic [31:0] unb);
		drain();
		write_reg(REG_ROUTE_MASK, mask);
		write_reg(REG_LEVER_PRESENT, {31'b0, lever});
		write_reg(REG_KEY_PRESENT, {31'b0, key});
		write_reg(REG_RELAY_PRESENT, {31'b0, relay});
		write_reg(REG_ACTIVATE_DELAY, act);
		write_reg(REG_KEEP_DELAY, keep);
		write_reg(REG_UNBLOCK_DELAY, unb);
		n_settings++;
	endtask

	task automatic random_phase(int n, int unsigned step_max, bit pause_midway);
		item_t it;
		int    roll;
		int    idx;
		logic  is_exit;
		gaps_on = coin(75);
		for (int i = 0; i < n; i++) begin
			if (pause_midway && i == n / 2)
				drain();
			roll = $urandom_range(0, 99);
			ms_now += $urandom_range(0, step_max);
			if (roll < 3)
				ms_now = $urandom;
			is_exit = scoreboard.route_mask > EXIT_THRESHOLD;
			it = build_item(REQ_TICK, ms_now, $urandom, coin(50), coin(50), coin(50),
				coin(50), coin(50));
			if (roll < 12) begin
				it.req_type = coin(50);
			end else if (roll < 18) begin
				it.req_type = REQ_START;
			end else if (roll < 24) begin
				it.switch_states = it.switch_states | scoreboard.route_mask;
			end else begin
				if (scoreboard.route_mask != '0) begin
					do idx = $urandom_range(0, 31); while (!scoreboard.route_mask[idx]);
					it.switch_states[idx] = 1'b0;
				end
				case (scoreboard.seq)
					ST_IDLE:        it.lever_on = coin(90);
					ST_WAITRELEASE: it.lever_on = coin(35);
					default:        it.lever_on = coin(80);
				endcase
				it.key_level      = coin(65);
				it.section_free   = coin(90);
				it.has_permission = is_exit ^ coin(12);
			end
			send_item(it);
		end
	endtask

	initial begin
		arst_n               = 1'b0;
		item_ch.valid        = 1'b0;
		item_ch.req_type     = REQ_TICK;
		item_ch.now          = '0;
		item_ch.switch_states = '1;
		item_ch.lever_on     = 1'b0;
		item_ch.key_level    = 1'b1;
		item_ch.section_free = 1'b0;
		item_ch.has_permission = 1'b0;
		item_ch.wait_for_key = 1'b0;
		result_ch.ready      = 1'b0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.index         = REG_ROUTE_MASK;
		cfg_ch.data          = '0;
		cycle_count          = 0;
		rx_count             = 0;
		rx_mode              = 0;
		burst_left           = 0;
		gaps_on              = 1'b0;
		n_settings           = 0;
		ms_now               = 32'd1000;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// exit route, key fitted: full cycle through every state
		apply_config(32'h0001_0000, 1'b1, 1'b1, 1'b1, 32'd2, 32'd3, 32'd1);
		send_item(build_item(REQ_TICK, 32'd100, 32'hFFFF_FFFF, 1, 1, 1, 1, 0));
		send_item(build_item(REQ_TICK, 32'd100, 32'h0000_0000, 1, 1, 1, 0, 0));
		send_item(build_item(REQ_TICK, 32'd100, 32'h0000_0000, 1, 1, 0, 1, 0));
		send_item(build_item(REQ_TICK, 32'd100, 32'hFFFE_FFFF, 1, 1, 1, 1, 0));
		send_item(build_item(REQ_TICK, 32'd102, 32'hFFFE_FFFF, 1, 1, 1, 1, 0));
		send_item(build_item(REQ_TICK, 32'd103, 32'hFFFE_FFFF, 1, 1, 1, 1, 0));
		send_item(build_item(REQ_TICK, 32'd106, 32'hFFFE_FFFF, 1, 1, 1, 1, 0));
		send_item(build_item(REQ_TICK, 32'd107, 32'hFFFE_FFFF, 1, 1, 1, 1, 0));
		send_item(build_item(REQ_TICK, 32'd108, 32'hFFFE_FFFF, 1, 0, 1, 1, 0));
		send_item(build_item(REQ_TICK, 32'd110, 32'hFFFE_FFFF, 1, 1, 1, 1, 0));
		send_item(build_item(REQ_TICK, 32'd111, 32'hFFFE_FFFF, 1, 1, 1, 1, 0));
		send_item(build_item(REQ_TICK, 32'd112, 32'hFFFE_FFFF, 0, 1, 1, 1, 0));
		send_item(build_item(REQ_START, 32'd113, 32'hFFFF_FFFF, 0, 1, 0, 0, 0));
		send_item(build_item(REQ_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, 1, 1));
		send_item(build_item(REQ_TICK, 32'd116, 32'hFFFE_FFFF, 1, 1, 1, 1, 0));
		send_item(build_item(REQ_TICK, 32'd117, 32'hFFFE_FFFF, 0, 1, 1, 1, 0));
		send_item(build_item(REQ_START, 32'd118, 32'hFFFF_FFFF, 0, 1, 0, 0, 1));

		// still waiting for the key when the key, lever and relay are removed
		apply_config(32'h0000_8000, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0);
		send_item(build_item(REQ_TICK, 32'd200, 32'hFFFF_7FFF, 1, 1, 1, 0, 0));
		send_item(build_item(REQ_TICK, 32'd201, 32'hFFFF_7FFF, 1, 0, 1, 0, 0));
		send_item(build_item(REQ_TICK, 32'd202, 32'hFFFF_7FFF, 1, 1, 1, 0, 0));
		send_item(build_item(REQ_TICK, 32'd203, 32'hFFFF_7FFF, 1, 1, 1, 0, 0));
		send_item(build_item(REQ_START, 32'hFFFF_FFF0, 32'h0000_0000, 1, 1, 1, 1, 1));
		send_item(build_item(REQ_TICK, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1, 1, 1, 1));
		send_item(build_item(REQ_TICK, 32'd0, 32'h0000_0000, 0, 0, 0, 0, 0));

		apply_config($urandom_range(1, 32'h7FFF), 1'b1, 1'b0, 1'b1,
			$urandom_range(0, 20), $urandom_range(0, 20), $urandom_range(0, 20));
		random_phase(PHASE_ITEMS, 12, 1'b1);
		apply_config(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1,
			$urandom_range(0, 20), $urandom_range(0, 20), $urandom_range(0, 20));
		random_phase(PHASE_ITEMS, 12, 1'b0);
		apply_config($urandom | 32'h0000_0100, 1'b1, 1'b1, 1'b0,
			$urandom_range(0, 20), $urandom_range(0, 20), $urandom_range(0, 20));
		random_phase(PHASE_ITEMS, 12, 1'b0);
		apply_config(32'h0000_8000, 1'b0, 1'b1, 1'b1,
			$urandom_range(0, 20), $urandom_range(0, 20), $urandom_range(0, 20));
		random_phase(PHASE_ITEMS, 12, 1'b0);
		apply_config(32'h0000_8001, 1'b1, 1'b0, 1'b1, 32'd0, 32'd0, 32'd0);
		ms_now = 32'hFFFF_FF00;
		random_phase(PHASE_ITEMS, 3, 1'b0);
		apply_config($urandom | 32'h0000_0001, 1'b1, 1'b1, 1'b1,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		random_phase(PHASE_ITEMS, 12, 1'b0);
		apply_config(32'h0000_0000, 1'b1, 1'b1, 1'b1, 32'd5, 32'd5, 32'd5);
		random_phase(PHASE_ITEMS, 12, 1'b0);
		apply_config($urandom_range(1, 32'hFFFF), 1'b1, 1'b0, 1'b1,
			DEFAULT_DELAY, DEFAULT_DELAY, DEFAULT_DELAY);
		random_phase(PHASE_ITEMS, 3000, 1'b0);

		drain();
		repeat (8) @(posedge clk);
		$display("Covered %0d items over %0d register settings, incl. wrapped and extreme delays.",
			scoreboard.n_items, n_settings);
		$display("%0d results compared; %0d block commands and %0d section releases seen.",
			scoreboard.n_checked, scoreboard.n_block, scoreboard.n_release);
		if (scoreboard.errors == 0 && scoreboard.pending() == 0)
			$display("route_block_sequencer_unit test passed");
		else
			$display("route_block_sequencer_unit test failed");
		$finish;
	end
endmodule
